>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define JETS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jets assertion failed");

// Check that a condition is followed by another in the next cycle.
`define JETS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("jets assertion failed");

`endif

>>> hw/rtl/jets_pkg.sv
// Shared types and constants of the Julia escape-time pixel unit.
`default_nettype none

package jets_pkg;

    localparam int PIX_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int ZOOM_W     = 31;
    localparam int COORD_W    = 32;
    localparam int LIMIT_W    = 31;
    localparam int DEN_W      = SIZE_W + ZOOM_W;
    localparam int MAG_W      = 13;
    localparam int COUNT_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IMAG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 3'd6;

    typedef struct packed {
        logic [SIZE_W-1:0]         image_size;
        logic [ZOOM_W-1:0]         zoom;
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic signed [COORD_W-1:0] center_real;
        logic signed [COORD_W-1:0] center_imag;
        logic [LIMIT_W-1:0]        escape_limit;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pix;

    typedef struct packed {
        logic signed [COORD_W-1:0] zx;
        logic signed [COORD_W-1:0] zy;
    } t_start;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/jets_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface jets_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/jets_front.sv
// Front end: pixel accept, start point mapping by restoring division.
`default_nettype none

module jets_front #(
    parameter int FRACTION_BITS = 24
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jets_pkg::t_cfg i_cfg,
    jets_stream_if.sink         i_pix,
    jets_stream_if.source       o_start
);
    import jets_pkg::*;

    localparam int NB     = MAG_W + 2 * FRACTION_BITS;
    localparam int STEP_W = $clog2(NB);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DEN  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_PUSH = 5'b10000
    } t_fr_state;

    t_fr_state                 r_state, n_state;
    logic                      r_sel;
    logic [PIX_W-1:0]          r_px, r_py;
    logic [DEN_W-1:0]          r_den, r_rem;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg, r_ovf;
    logic [COORD_W-1:0]        r_q;
    logic [STEP_W-1:0]         r_step;
    logic signed [COORD_W-1:0] r_zx, r_zy;

    logic [SIZE_W-1:0]         w_size;
    logic [ZOOM_W-1:0]         w_zoom;
    logic [PIX_W-1:0]          w_src;
    logic signed [MAG_W:0]     w_diff;
    logic                      w_neg;
    logic [MAG_W-1:0]          w_mag;
    logic [DEN_W:0]            w_rem_sh, w_rem_sub;
    logic                      w_ge;
    logic [DEN_W-1:0]          w_rem_nx;
    logic                      w_big;
    logic signed [COORD_W-1:0] w_qs, w_center, w_coord;
    logic signed [COORD_W:0]   w_sum;
    logic                      w_last;
    t_start                    w_start;

    assign w_size = (i_cfg.image_size == '0) ? SIZE_W'(1) : i_cfg.image_size;
    assign w_zoom = (i_cfg.zoom == '0) ? ZOOM_W'(1) : i_cfg.zoom;

    assign w_src  = (r_state == ST_DEN) ? r_px : r_py;
    assign w_diff = $signed({1'b0, w_src, 1'b0}) - $signed({1'b0, w_size});
    assign w_neg  = w_diff[MAG_W];
    assign w_mag  = w_neg ? MAG_W'(-w_diff) : w_diff[MAG_W-1:0];

    assign w_rem_sh  = {r_rem, r_mag[MAG_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx  = w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
    assign w_last    = (r_step == STEP_W'(NB - 1));

    assign w_big = r_neg ? (r_ovf || (r_q[COORD_W-1] && (r_q[COORD_W-2:0] != '0)))
                         : (r_ovf || r_q[COORD_W-1]);
    assign w_qs  = w_big ? (r_neg ? SAT_MIN : SAT_MAX)
                         : (r_neg ? -$signed(r_q) : $signed(r_q));
    assign w_center = r_sel ? i_cfg.center_imag : i_cfg.center_real;
    assign w_sum    = {w_qs[COORD_W-1], w_qs} + {w_center[COORD_W-1], w_center};
    assign w_coord  = (w_sum[COORD_W] != w_sum[COORD_W-1])
                    ? (w_sum[COORD_W] ? SAT_MIN : SAT_MAX)
                    : w_sum[COORD_W-1:0];

    assign i_pix.ready   = (r_state == ST_IDLE);
    assign o_start.valid = (r_state == ST_PUSH);
    assign w_start.zx    = r_zx;
    assign w_start.zy    = r_zy;
    assign o_start.data  = w_start;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) n_state = ST_DEN;
            end
            ST_DEN: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_last) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = r_sel ? ST_PUSH : ST_DIV;
            end
            ST_PUSH: begin
                if (o_start.ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DEN) r_sel <= 1'b0;
            else if (r_state == ST_FIN) r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    r_px <= i_pix.data.pixel_x;
                    r_py <= i_pix.data.pixel_y;
                end
            end
            ST_DEN: begin
                r_den  <= DEN_W'(w_size) * DEN_W'(w_zoom);
                r_mag  <= w_mag;
                r_neg  <= w_neg;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_mag  <= r_mag << 1;
                r_rem  <= w_rem_nx;
                r_q    <= {r_q[COORD_W-2:0], w_ge};
                r_ovf  <= r_ovf | r_q[COORD_W-1];
                r_step <= r_step + STEP_W'(1);
            end
            ST_FIN: begin
                if (!r_sel) begin
                    r_zx   <= w_coord;
                    r_mag  <= w_mag;
                    r_neg  <= w_neg;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_zy <= w_coord;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/jets_queue.sv
// Short start point queue between front and back end.
`default_nettype none
`include "assert_macros.svh"

module jets_queue (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    jets_stream_if.sink   i_push,
    jets_stream_if.source o_pop
);
    import jets_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_start           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign i_push.ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_mem[r_rp];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) r_cnt <= r_cnt + CNT_W'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_push.data;
    end

    `JETS_ASSERT(a_q_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

>>> hw/rtl/jets_back.sv
// Back end: escape-time iteration, color packing and result register.
`default_nettype none
`include "assert_macros.svh"

module jets_back #(
    parameter int MAX_STEPS     = 255,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jets_pkg::t_cfg i_cfg,
    jets_stream_if.sink         i_start,
    jets_stream_if.source       o_res
);
    import jets_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int PW     = PROD_W - FRACTION_BITS;
    localparam int SW     = PW + 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } t_bk_state;

    t_bk_state                 r_state, n_state;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [PW-1:0]      r_xx, r_yy, r_xy;
    logic [COUNT_W-1:0]        r_cnt, r_res;
    logic                      r_chk;
    logic                      r_ov;
    t_res                      r_out;

    logic signed [PROD_W-1:0]  w_pxx, w_pyy, w_pxy;
    logic signed [SW-1:0]      w_xx_e, w_yy_e, w_cr_e, w_ci_e, w_lim_e;
    logic signed [SW-1:0]      w_re_sum, w_im_sum, w_norm;
    logic                      w_esc, w_fin, w_slot_free;
    logic [COLOR_W-1:0]        w_color;
    t_res                      w_res;

    function automatic logic signed [COORD_W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [COORD_W-1:0] res;
        if ((v[SW-1:COORD_W-1] == '0) || (v[SW-1:COORD_W-1] == '1)) begin
            res = v[COORD_W-1:0];
        end else begin
            res = v[SW-1] ? SAT_MIN : SAT_MAX;
        end
        return res;
    endfunction

    assign w_pxx = r_x * r_x;
    assign w_pyy = r_y * r_y;
    assign w_pxy = r_x * r_y;

    assign w_xx_e   = {{2{r_xx[PW-1]}}, r_xx};
    assign w_yy_e   = {{2{r_yy[PW-1]}}, r_yy};
    assign w_cr_e   = {{(SW-COORD_W){i_cfg.c_real[COORD_W-1]}}, i_cfg.c_real};
    assign w_ci_e   = {{(SW-COORD_W){i_cfg.c_imag[COORD_W-1]}}, i_cfg.c_imag};
    assign w_lim_e  = {{(SW-LIMIT_W){1'b0}}, i_cfg.escape_limit};
    assign w_re_sum = w_xx_e - w_yy_e + w_cr_e;
    assign w_im_sum = {r_xy[PW-1], r_xy, 1'b0} + w_ci_e;
    assign w_norm   = w_xx_e + w_yy_e;

    assign w_esc       = r_chk && (w_norm >= w_lim_e);
    assign w_fin       = w_esc || (r_chk && (r_cnt == COUNT_W'(1)));
    assign w_slot_free = !r_ov || o_res.ready;

    assign w_color = (COLOR_W'(r_res) << 21) + (COLOR_W'(r_res) << 10)
                   + (COLOR_W'(r_res) << 3);
    assign w_res.step_count = r_res;
    assign w_res.red        = w_color[23:16];
    assign w_res.green      = w_color[15:8];
    assign w_res.blue       = w_color[7:0];

    assign i_start.ready = (r_state == ST_IDLE);
    assign o_res.valid   = r_ov;
    assign o_res.data    = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start.valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = w_fin ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_slot_free) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start.valid) begin
                    r_x   <= i_start.data.zx;
                    r_y   <= i_start.data.zy;
                    r_cnt <= COUNT_W'(MAX_STEPS);
                    r_chk <= 1'b0;
                end
            end
            ST_MUL: begin
                r_xx <= w_pxx[PROD_W-1:FRACTION_BITS];
                r_yy <= w_pyy[PROD_W-1:FRACTION_BITS];
                r_xy <= w_pxy[PROD_W-1:FRACTION_BITS];
            end
            ST_UPD: begin
                if (w_fin) begin
                    r_res <= w_esc ? r_cnt : '0;
                end else begin
                    r_x   <= f_sat(w_re_sum);
                    r_y   <= f_sat(w_im_sum);
                    r_chk <= 1'b1;
                    if (r_chk) r_cnt <= r_cnt - COUNT_W'(1);
                end
            end
            ST_DONE: begin
                if (w_slot_free) r_out <= w_res;
            end
            default: begin
            end
        endcase
    end

    `JETS_ASSERT(a_bk_cnt_live, i_clk, i_rst_n, ((r_state == ST_MUL) || (r_state == ST_UPD)) |-> (r_cnt != '0))
    `JETS_ASSERT(a_bk_out_from_done, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state == ST_DONE))
    `JETS_ASSERT_NEXT(a_bk_pop_starts, i_clk, i_rst_n, i_start.valid && i_start.ready, (r_state == ST_MUL) && !r_chk)

endmodule

`default_nettype wire

>>> hw/rtl/julia_escape_time_pixel_unit.sv
// Julia escape-time pixel unit: config registers, front end, queue, back end.
// Front maps a pixel by restoring division, one bit a cycle (Q8.24 at FRACTION_BITS = 24).
// Back runs each round as a multiply step then an update step on three 32x32 multipliers.
// Start points pass from front to back through the registered queue.
// Throughput is one pixel per slower side.
// Reset is synchronous, active low: registers take defaults, queue and result slot empty.
`default_nettype none

module julia_escape_time_pixel_unit #(
    parameter int MAX_STEPS     = 255,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [jets_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [jets_pkg::CFG_DATA_W-1:0] i_cfg_data,
    jets_stream_if.sink                          i_pix,
    jets_stream_if.source                        o_res
);
    import jets_pkg::*;

    localparam logic [ZOOM_W-1:0]  ZOOM_RESET  = ZOOM_W'(1) << FRACTION_BITS;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2) << FRACTION_BITS;

    t_cfg r_cfg;

    jets_stream_if #(.t_data(t_start)) w_fr_q ();
    jets_stream_if #(.t_data(t_start)) w_q_bk ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_size   <= SIZE_RESET;
            r_cfg.zoom         <= ZOOM_RESET;
            r_cfg.c_real       <= '0;
            r_cfg.c_imag       <= '0;
            r_cfg.center_real  <= '0;
            r_cfg.center_imag  <= '0;
            r_cfg.escape_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_SIZE:   r_cfg.image_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_ZOOM:         r_cfg.zoom         <= i_cfg_data[ZOOM_W-1:0];
                CFG_C_REAL:       r_cfg.c_real       <= $signed(i_cfg_data);
                CFG_C_IMAG:       r_cfg.c_imag       <= $signed(i_cfg_data);
                CFG_CENTER_REAL:  r_cfg.center_real  <= $signed(i_cfg_data);
                CFG_CENTER_IMAG:  r_cfg.center_imag  <= $signed(i_cfg_data);
                CFG_ESCAPE_LIMIT: r_cfg.escape_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    jets_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .o_start (w_fr_q.source)
    );

    jets_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_q.sink),
        .o_pop   (w_q_bk.source)
    );

    jets_back #(
        .MAX_STEPS     (MAX_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (w_q_bk.sink),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
